[hdl/wccs_pkg.sv]
// ----------------------------------------------------------------------------
// wccs_pkg: shared types and constants of the chirp cosine synthesizer
// Register map, configuration record and fixed field widths.
// ----------------------------------------------------------------------------
package wccs_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int FIELD_W     = 16;
  localparam int CFG_W       = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic REG_FREQ_STEP  = 1'b0;
  localparam logic REG_CHIRP_RATE = 1'b1;

  typedef struct packed {
    logic        [CFG_W-1:0] freq_step;
    logic signed [CFG_W-1:0] chirp_rate;
  } cfg_t;

endpackage

[hdl/wccs_front.sv]
// ----------------------------------------------------------------------------
// wccs_front: phase accumulator front end
// Accepts transactions, restarts or advances the chirp phase and pushes the
// angle, window and amplitude of each sample into the work queue.
// ----------------------------------------------------------------------------
module wccs_front import wccs_pkg::*; #(
  parameter int PHASE_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_t                      cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      start_of_atom,
  input  logic [FIELD_W-1:0]        window_sample,
  input  logic [FIELD_W-1:0]        amplitude,
  input  logic [FIELD_W-1:0]        phase_offset,
  output logic                      push_valid,
  input  logic                      push_ready,
  output logic [PHASE_BITS+2*FIELD_W-1:0] push_data
);

  localparam int PB = PHASE_BITS;

  logic [PB-1:0] phase_acc, phase_acc_next;
  logic [PB-1:0] phase_step, phase_step_next;
  logic [PB+CFG_W-1:0]   freq_ext, chirp_ext;
  logic [PB+FIELD_W-1:0] off_ext;
  logic [PB-1:0] freq_p, chirp_p, off_p, acc_use, step_use, angle;
  logic          take;

  assign freq_ext  = {cfg.freq_step, PB'(0)};
  assign chirp_ext = {cfg.chirp_rate, PB'(0)};
  assign off_ext   = {phase_offset, PB'(0)};
  assign freq_p    = freq_ext[PB+CFG_W-1:CFG_W];
  assign chirp_p   = chirp_ext[PB+CFG_W-1:CFG_W];
  assign off_p     = off_ext[PB+FIELD_W-1:FIELD_W];

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign take       = in_valid && push_ready;

  always_comb begin
    if (start_of_atom) begin
      acc_use  = '0;
      step_use = freq_p + {chirp_p[PB-1], chirp_p[PB-1:1]};
    end else begin
      acc_use  = phase_acc;
      step_use = phase_step;
    end
    angle           = acc_use + off_p;
    phase_acc_next  = acc_use + step_use;
    phase_step_next = step_use + chirp_p;
  end

  assign push_data = {amplitude, window_sample, angle};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc  <= '0;
      phase_step <= '0;
    end else if (take) begin
      phase_acc  <= phase_acc_next;
      phase_step <= phase_step_next;
    end
  end

endmodule

[hdl/wccs_queue.sv]
// ----------------------------------------------------------------------------
// wccs_queue: short work queue
// Decouples the phase front end from the cosine back end.
// ----------------------------------------------------------------------------
module wccs_queue import wccs_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0]    entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                push, pop;

  assign in_ready  = count != (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/wccs_back.sv]
// ----------------------------------------------------------------------------
// wccs_back: cosine lookup and scaling back end
// Four-stage pipeline: table index, quarter-wave lookup, window-amplitude
// product, round and saturate into the output register.
// ----------------------------------------------------------------------------
module wccs_back import wccs_pkg::*; #(
  parameter int COS_TABLE_DEPTH = 1024,
  parameter int PHASE_BITS      = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  logic [PHASE_BITS+2*FIELD_W-1:0] pop_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [SAMPLE_W-1:0]             sample
);

  localparam int PB = PHASE_BITS;
  localparam int FB = PHASE_BITS - 2;
  localparam int DW = $clog2(COS_TABLE_DEPTH + 1);
  localparam int PW = FB + DW;

  function automatic logic [15:0] rom_entry(input int unsigned k);
    longint unsigned theta, th2, term, v;
    longint          sum;
    theta = (64'd1686629713 * longint'(k)) / COS_TABLE_DEPTH;
    th2   = (theta * theta) >> 30;
    term  = 64'd1073741824;
    sum   = 64'sd1073741824;
    term  = ((term * th2) >> 30) / 64'd2;
    sum   = sum - longint'(term);
    term  = ((term * th2) >> 30) / 64'd12;
    sum   = sum + longint'(term);
    term  = ((term * th2) >> 30) / 64'd30;
    sum   = sum - longint'(term);
    term  = ((term * th2) >> 30) / 64'd56;
    sum   = sum + longint'(term);
    term  = ((term * th2) >> 30) / 64'd90;
    sum   = sum - longint'(term);
    term  = ((term * th2) >> 30) / 64'd132;
    sum   = sum + longint'(term);
    term  = ((term * th2) >> 30) / 64'd182;
    sum   = sum - longint'(term);
    term  = ((term * th2) >> 30) / 64'd240;
    sum   = sum + longint'(term);
    term  = ((term * th2) >> 30) / 64'd306;
    sum   = sum - longint'(term);
    if (sum < 0) sum = 0;
    v = (longint'(sum) * 64'd32767 + 64'd536870912) >> 30;
    if (v > 64'd32767) v = 64'd32767;
    return v[15:0];
  endfunction

  logic [15:0] cos_rom [COS_TABLE_DEPTH+1];

  for (genvar k = 0; k <= COS_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [15:0] ENTRY = rom_entry(k);
    assign cos_rom[k] = ENTRY;
  end

  logic          advance;
  logic          s1_v, s2_v, s3_v;
  logic [PB-1:0] angle;
  logic [FIELD_W-1:0] win, amp;
  logic [2*FIELD_W-1:0] wa_full;
  logic [PW-1:0] idx_prod;

  logic [DW-1:0]      s1_idx;
  logic [1:0]         s1_q;
  logic [FIELD_W-1:0] s1_wa;

  logic [DW-1:0]      rom_addr;
  logic [14:0]        s2_cos;
  logic               s2_neg;
  logic [FIELD_W-1:0] s2_wa;

  logic [30:0]        s3_mag;
  logic               s3_neg;

  logic [31:0]        rnd_sum;
  logic signed [16:0] pos17, rnd17, p17;
  logic [SAMPLE_W-1:0] sat;

  assign advance   = !out_valid || out_ready;
  assign pop_ready = advance;

  assign angle    = pop_data[PB-1:0];
  assign win      = pop_data[PB+FIELD_W-1:PB];
  assign amp      = pop_data[PB+2*FIELD_W-1:PB+FIELD_W];
  assign wa_full  = (2*FIELD_W)'(win) * (2*FIELD_W)'(amp);
  assign idx_prod = PW'(angle[FB-1:0]) * PW'(COS_TABLE_DEPTH);
  assign rom_addr = s1_q[0] ? DW'(COS_TABLE_DEPTH) - s1_idx : s1_idx;

  always_comb begin
    rnd_sum = 32'(s3_mag) + 32'd65535;
    pos17   = 17'(s3_mag >> 16);
    rnd17   = 17'(rnd_sum >> 16);
    p17     = s3_neg ? -rnd17 : pos17;
    if (p17 > 17'sd32767) begin
      sat = 16'h7fff;
    end else if (p17 < -17'sd32768) begin
      sat = 16'h8000;
    end else begin
      sat = p17[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_idx <= idx_prod[PW-1:FB];
      s1_q   <= angle[PB-1:PB-2];
      s1_wa  <= wa_full[2*FIELD_W-1:FIELD_W];
      s2_cos <= cos_rom[rom_addr][14:0];
      s2_neg <= s1_q[1] ^ s1_q[0];
      s2_wa  <= s1_wa;
      s3_mag <= 31'(s2_wa) * 31'(s2_cos);
      s3_neg <= s2_neg;
      sample <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_v      <= pop_valid;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      out_valid <= s3_v;
    end
  end

endmodule

[hdl/windowed_chirp_cosine_synth_core.sv]
// ----------------------------------------------------------------------------
// windowed_chirp_cosine_synth_core: windowed chirp cosine synthesizer
// Streams one windowed, amplitude-scaled linear-chirp cosine sample per input.
//
// Input stream s_*: tuser is start_of_atom; a set flag restarts the phase
// (phase 0, step = freq_step + chirp_rate/2). Output stream m_*: one sample
// per input, in order.
// Configuration: APB registers freq_step at 0x0 and chirp_rate at 0x4;
// write only while the stream is idle.
// Throughput: one sample per clock while m_tready holds no stall; the phase
// front end updates both accumulators in the same cycle. On its way to
// m_tvalid, an accepted transaction lands in the queue at acceptance,
// then passes the index, table, product and output register stages.
// The front end keeps accepting while the four-entry queue has room, so a
// stalled receiver backs up into s_tready only after the queue fills. The
// output holds its sample while m_tready is low.
// Reset: clears phase, registers, queue and pipeline valids; no sweep needed.
// ----------------------------------------------------------------------------
module windowed_chirp_cosine_synth_core import wccs_pkg::*; #(
  parameter int COS_TABLE_DEPTH = 1024,
  parameter int PHASE_BITS      = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [47:0]         s_tdata,  // window_sample, amplitude, phase_offset
  input  logic                s_tuser,  // start_of_atom
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [SAMPLE_W-1:0] m_tdata,  // sample
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int QW = PHASE_BITS + 2 * FIELD_W;

  cfg_t          cfg;
  logic          reg_sel;
  logic          wr_en;
  logic          push_valid, push_ready, pop_valid, pop_ready;
  logic [QW-1:0] push_data, pop_data;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_sel)
      REG_FREQ_STEP:  prdata = cfg.freq_step;
      REG_CHIRP_RATE: prdata = cfg.chirp_rate;
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_FREQ_STEP:  cfg.freq_step  <= pwdata;
        REG_CHIRP_RATE: cfg.chirp_rate <= pwdata;
        default:        cfg <= cfg;
      endcase
    end
  end

  wccs_front #(.PHASE_BITS(PHASE_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .start_of_atom (s_tuser),
    .window_sample (s_tdata[15:0]),
    .amplitude     (s_tdata[31:16]),
    .phase_offset  (s_tdata[47:32]),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  wccs_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_data   (push_data),
    .out_valid (pop_valid),
    .out_ready (pop_ready),
    .out_data  (pop_data)
  );

  wccs_back #(
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH),
    .PHASE_BITS      (PHASE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sample    (m_tdata)
  );

endmodule

[hdl/wccs_checker.sv]
// ----------------------------------------------------------------------------
// wccs_checker: port-level checks of the synthesizer
// Tracks outstanding transactions and checks reset, output stall and register readback.
// ----------------------------------------------------------------------------
module wccs_checker import wccs_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [SAMPLE_W-1:0] m_tdata,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [2:0]          paddr,
  input logic [31:0]         pwdata,
  input logic [31:0]         prdata
);

  logic [4:0] outstanding;
  logic       in_acc, out_acc;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (in_acc && !out_acc) begin
      outstanding <= outstanding + 1'b1;
    end else if (out_acc && !in_acc) begin
      outstanding <= outstanding - 1'b1;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> outstanding != '0)
    else $error("sample shown with no transaction outstanding");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output changed");

  a_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite) ##1 (psel && !pwrite && paddr == $past(paddr))
    |-> prdata == $past(pwdata))
    else $error("register readback mismatch");

endmodule

bind windowed_chirp_cosine_synth_core wccs_checker u_wccs_checker (.*);
